[hdl/trvr_pkg.sv]
// Shared types and constants for the reduced-round Trivium bit block.
`default_nettype none
package trvr_pkg;

    localparam int unsigned LEN_A   = 93;
    localparam int unsigned LEN_B   = 84;
    localparam int unsigned LEN_C   = 111;
    localparam int unsigned KEY_W   = 80;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned OFF_W   = 7;

    localparam logic [CFG_W-1:0] WARMUP       = 11'd64;
    localparam logic [CFG_W-1:0] ROUNDS_RESET = 11'd721;
    localparam logic [CFG_W-1:0] PROBE_RESET  = 11'd290;

    // Configuration register indexes
    localparam logic REG_ROUNDS = 1'b0;
    localparam logic REG_PROBE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } trvr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } trvr_ctrl_t;

endpackage
`default_nettype wire

[hdl/reduced_round_trivium_bit_top.sv]
// Reduced-round Trivium keystream bit: sequencer, configuration and result register.
// A transaction loads key and IV on acceptance, runs rounds-64 update steps (none
// when rounds <= 64) and then finishes into the output register.
// Only one transaction is in the core at a time; the single update unit does one
// state step per cycle. A finished result may wait in the output register while
// the next transaction is taken. Reset sets rounds to 721, probe_update to 290.
`default_nettype none
module reduced_round_trivium_bit_top
    import trvr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [63:0]         s_key_low,
    input  wire logic [HALF_W-1:0]   s_key_high,
    input  wire logic [63:0]         s_iv_low,
    input  wire logic [HALF_W-1:0]   s_iv_high,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_stream_bit,
    output logic                     m_probe_bit
);

    trvr_state_t      state_reg, state_next;
    trvr_ctrl_t       ctrl;
    logic [CFG_W-1:0] rounds_reg, probe_reg;
    logic [CFG_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] n_upd;
    logic [OFF_W-1:0] tap_off;
    logic             last_step, out_load, accept;
    logic             probe_bit_reg, probe_bit_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_stream_reg, m_probe_reg;
    logic             new_b, stream_bit;

    assign n_upd   = (rounds_reg > WARMUP) ? (rounds_reg - WARMUP) : '0;
    assign tap_off = (rounds_reg >= WARMUP) ? OFF_W'(WARMUP) : rounds_reg[OFF_W-1:0];
    assign last_step = ({1'b0, cnt_reg} + 12'd1) == {1'b0, n_upd};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rounds_reg <= ROUNDS_RESET;
            probe_reg  <= PROBE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROUNDS: rounds_reg <= cfg_wdata;
                REG_PROBE:  probe_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = (n_upd == '0) ? ST_FINISH : ST_RUN;
            end
            ST_RUN: begin
                if (last_step) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        accept    = s_valid && s_ready;
        ctrl.load = accept;
        ctrl.step = (state_reg == ST_RUN);
        out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        cnt_next       = cnt_reg;
        probe_bit_next = probe_bit_reg;
        if (accept) begin
            cnt_next       = '0;
            probe_bit_next = 1'b0;
        end else if (ctrl.step) begin
            cnt_next = cnt_reg + 11'd1;
            // capture the B bit made by the probed update
            if (cnt_reg == probe_reg) probe_bit_next = new_b;
        end
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        probe_bit_reg <= probe_bit_next;
        if (out_load) begin
            m_stream_reg <= stream_bit;
            m_probe_reg  <= probe_bit_reg;
        end
    end

    trvr_core u_core (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .key        ({s_key_high, s_key_low}),
        .iv         ({s_iv_high, s_iv_low}),
        .tap_off    (tap_off),
        .new_b      (new_b),
        .stream_bit (stream_bit)
    );

    assign m_valid      = m_valid_reg;
    assign m_stream_bit = m_stream_reg;
    assign m_probe_bit  = m_probe_reg;

endmodule
`default_nettype wire

[hdl/trvr_core.sv]
// Trivium state registers with the shared one-step update and keystream taps.
`default_nettype none
module trvr_core
    import trvr_pkg::*;
(
    input  wire logic                aclk,
    input  wire trvr_ctrl_t          ctrl,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [KEY_W-1:0]    iv,
    input  wire logic [OFF_W-1:0]    tap_off,
    output logic                     new_b,
    output logic                     stream_bit
);

    // Index 0 is the oldest bit of each register window.
    logic [LEN_A-1:0] a_reg, a_next, a_load;
    logic [LEN_B-1:0] b_reg, b_next, b_load;
    logic [LEN_C-1:0] c_reg, c_next, c_load;
    logic             new_a, new_c;

    always_comb begin
        a_load = '0;
        b_load = '0;
        c_load = '0;
        for (int i = 0; i < KEY_W; i++) begin
            a_load[LEN_A-1-i] = key[i];
            b_load[LEN_B-1-i] = iv[i];
        end
        c_load[2:0] = 3'b111;
    end

    assign new_a = c_reg[45] ^ (c_reg[1] & c_reg[2]) ^ c_reg[0] ^ a_reg[24];
    assign new_b = a_reg[27] ^ (a_reg[1] & a_reg[2]) ^ a_reg[0] ^ b_reg[6];
    assign new_c = b_reg[15] ^ (b_reg[1] & b_reg[2]) ^ b_reg[0] ^ c_reg[24];

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        if (ctrl.load) begin
            a_next = a_load;
            b_next = b_load;
            c_next = c_load;
        end else if (ctrl.step) begin
            // drop the oldest bit, append the new one
            a_next = {new_a, a_reg[LEN_A-1:1]};
            b_next = {new_b, b_reg[LEN_B-1:1]};
            c_next = {new_c, c_reg[LEN_C-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
    end

    logic [OFF_W-1:0] ia_hi, ib_hi, ic_hi, i_lo;

    assign ia_hi = tap_off + 7'd28;
    assign ib_hi = tap_off + 7'd16;
    assign ic_hi = tap_off + 7'd46;
    assign i_lo  = tap_off + 7'd1;

    assign stream_bit = a_reg[ia_hi] ^ a_reg[i_lo] ^ b_reg[ib_hi] ^ b_reg[i_lo]
                      ^ c_reg[ic_hi] ^ c_reg[i_lo];

endmodule
`default_nettype wire
